// ===== rtl/hsl_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl_pkg
// constants, sector codes and helpers for the hsl to rgb pixel converter
// ----------------------------------------------------------------------------
package hsl_pkg;

   localparam int unsigned HueW   = 15;
   localparam int unsigned ChanW  = 16;
   localparam int unsigned FracW  = 12;                  // hue offset inside a sector

   localparam logic [HueW-1:0]  HUE_MAX      = 15'd23039;  // 360 degrees less one unit
   localparam logic [FracW-1:0] SECTOR_UNITS = 12'd3840;   // 60 degrees in 1/64 degree
   localparam logic [ChanW-1:0] FULL         = 16'hFFFF;

   // rounding offsets of the two scaled products
   localparam logic [31:0] ROUND_C = 32'd32767;          // half down on /65535
   localparam logic [27:0] ROUND_X = 28'd1920;           // half up on /3840

   // x / 15 as (x * RECIP_15) >> RECIP_SHIFT, exact for x below 2^24 / 14
   localparam int unsigned RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP_15    = 21'd1118482;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // first hue code of each sector
   function automatic logic [HueW-1:0] sector_base(input sector_type sec);
      logic [HueW-1:0] base;
      case (sec)
         SEC_RED_YEL: base = 15'd0;
         SEC_YEL_GRN: base = 15'd3840;
         SEC_GRN_CYN: base = 15'd7680;
         SEC_CYN_BLU: base = 15'd11520;
         SEC_BLU_MAG: base = 15'd15360;
         SEC_MAG_RED: base = 15'd19200;
         default:     base = 15'd0;
      endcase
      return base;
   endfunction

   // limit a 17 bit half-unit sum to full scale
   function automatic logic [ChanW-1:0] sat16(input logic [ChanW:0] v);
      return v[ChanW] ? FULL : v[ChanW-1:0];
   endfunction

endpackage

// ===== rtl/hsl_to_rgb_convert.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_convert
// six stage pipelined hsl (with alpha) to rgb (with alpha) pixel converter
// ----------------------------------------------------------------------------
// One pixel per beat, one pixel out per beat, sustained one pixel per clock
// while rsp is ready. rsp_valid is the last stage's valid bit. The pipeline
// is six register stages, each holding a valid bit: hue sector and lightness
// fold, the chroma product, the /65535 scaling, the chroma-by-hue product,
// the /3840 reciprocal product, and the channel sums with routing into the
// output register. Each stage advances when it is empty or the stage after
// it advances, so bubbles close up under a stall and req_ready only drops
// when all six stages hold pixels and rsp is stalled. Hue above 23039 is
// treated as 23039; channels saturate at 65535; alpha is carried unchanged.
// ----------------------------------------------------------------------------
module hsl_to_rgb_convert
   import hsl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [HueW-1:0]  req_hue,
   input  logic [ChanW-1:0] req_saturation,
   input  logic [ChanW-1:0] req_lightness,
   input  logic [ChanW-1:0] req_alpha_in,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ChanW-1:0] rsp_red,
   output logic [ChanW-1:0] rsp_green,
   output logic [ChanW-1:0] rsp_blue,
   output logic [ChanW-1:0] rsp_alpha_out
);

   localparam int unsigned NumStages = 6;

   // per stage valid bits and advance enables
   logic [NumStages-1:0] vld_ff, vld_in;
   logic [NumStages-1:0] adv;

   // stage 1: sector, hue fraction, folded lightness
   sector_type       s1_sec_ff,  s1_sec_in;
   logic [FracW-1:0] s1_f_ff,    s1_f_in;
   logic [ChanW-1:0] s1_cs_ff,   s1_cs_in;    // 1 - |2L - 1|
   logic [ChanW-1:0] s1_s_ff;
   logic [ChanW:0]   s1_twol_ff, s1_twol_in;
   logic [ChanW-1:0] s1_a_ff;

   // stage 2: chroma product
   sector_type       s2_sec_ff;
   logic [FracW-1:0] s2_f_ff;
   logic [31:0]      s2_p_ff,    s2_p_in;
   logic [ChanW:0]   s2_twol_ff;
   logic [ChanW-1:0] s2_a_ff;

   // stage 3: chroma
   sector_type       s3_sec_ff;
   logic [FracW-1:0] s3_f_ff;
   logic [ChanW-1:0] s3_c_ff,    s3_c_in;
   logic [ChanW:0]   s3_twol_ff;
   logic [ChanW-1:0] s3_a_ff;

   // stage 4: chroma times hue fraction, rounded
   sector_type       s4_sec_ff;
   logic [27:0]      s4_cf_ff,   s4_cf_in;
   logic [ChanW-1:0] s4_c_ff;
   logic [ChanW:0]   s4_twol_ff;
   logic [ChanW-1:0] s4_a_ff;

   // stage 5: reciprocal product for /15
   sector_type       s5_sec_ff;
   logic [40:0]      s5_q_ff,    s5_q_in;
   logic [ChanW-1:0] s5_c_ff;
   logic [ChanW:0]   s5_twol_ff;
   logic [ChanW-1:0] s5_a_ff;

   // stage 6: output register
   logic [ChanW-1:0] s6_r_ff, s6_r_in;
   logic [ChanW-1:0] s6_g_ff, s6_g_in;
   logic [ChanW-1:0] s6_b_ff, s6_b_in;
   logic [ChanW-1:0] s6_a_ff;

   // ------------------------------------------------------------------------
   // flow control: a stage moves when empty or when its successor moves
   // ------------------------------------------------------------------------
   always_comb begin
      adv[NumStages-1] = !vld_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < NumStages; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: clamp hue, find sector and offset, fold lightness
   // ------------------------------------------------------------------------
   logic [HueW-1:0] hue_c;
   logic [2:0]      sec_cnt;
   logic [HueW-1:0] hue_off;

   always_comb begin
      hue_c   = (req_hue > HUE_MAX) ? HUE_MAX : req_hue;
      sec_cnt = 3'(hue_c >= 15'd3840)  + 3'(hue_c >= 15'd7680) + 3'(hue_c >= 15'd11520)
              + 3'(hue_c >= 15'd15360) + 3'(hue_c >= 15'd19200);
      s1_sec_in = sector_type'(sec_cnt);
      hue_off   = hue_c - sector_base(s1_sec_in);
      // falling half of the triangle wave in odd sectors
      s1_f_in   = sec_cnt[0] ? (SECTOR_UNITS - hue_off[FracW-1:0]) : hue_off[FracW-1:0];

      s1_twol_in = {req_lightness, 1'b0};
      if (s1_twol_in >= {1'b0, FULL}) begin
         s1_cs_in = FULL - ChanW'(s1_twol_in - {1'b0, FULL});
      end else begin
         s1_cs_in = FULL - ChanW'({1'b0, FULL} - s1_twol_in);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_sec_ff  <= s1_sec_in;
         s1_f_ff    <= s1_f_in;
         s1_cs_ff   <= s1_cs_in;
         s1_s_ff    <= req_saturation;
         s1_twol_ff <= s1_twol_in;
         s1_a_ff    <= req_alpha_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: (1 - |2L - 1|) * S, plus rounding offset
   // ------------------------------------------------------------------------
   assign s2_p_in = ({16'd0, s1_cs_ff} * {16'd0, s1_s_ff}) + ROUND_C;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_sec_ff  <= s1_sec_ff;
         s2_f_ff    <= s1_f_ff;
         s2_p_ff    <= s2_p_in;
         s2_twol_ff <= s1_twol_ff;
         s2_a_ff    <= s1_a_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: divide by 65535; t = hi*65535 + (hi + lo), hi + lo below 2*65535+1
   // ------------------------------------------------------------------------
   logic [ChanW:0] rem_sum;
   logic [ChanW:0] c_wide;

   always_comb begin
      rem_sum = {1'b0, s2_p_ff[31:16]} + {1'b0, s2_p_ff[15:0]};
      c_wide  = {1'b0, s2_p_ff[31:16]}
              + 17'(rem_sum >= {1'b0, FULL})
              + 17'(rem_sum >= {FULL, 1'b0});
      s3_c_in = c_wide[ChanW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_sec_ff  <= s2_sec_ff;
         s3_f_ff    <= s2_f_ff;
         s3_c_ff    <= s3_c_in;
         s3_twol_ff <= s2_twol_ff;
         s3_a_ff    <= s2_a_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: C * f + 1920
   // ------------------------------------------------------------------------
   assign s4_cf_in = ({12'd0, s3_c_ff} * {16'd0, s3_f_ff}) + ROUND_X;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_sec_ff  <= s3_sec_ff;
         s4_cf_ff   <= s4_cf_in;
         s4_c_ff    <= s3_c_ff;
         s4_twol_ff <= s3_twol_ff;
         s4_a_ff    <= s3_a_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 5: /3840 as >>8 then /15 by reciprocal
   // ------------------------------------------------------------------------
   assign s5_q_in = {21'd0, s4_cf_ff[27:8]} * {20'd0, RECIP_15};

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_sec_ff  <= s4_sec_ff;
         s5_q_ff    <= s5_q_in;
         s5_c_ff    <= s4_c_ff;
         s5_twol_ff <= s4_twol_ff;
         s5_a_ff    <= s4_a_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 6: half-unit sums, saturate, route by sector
   // ------------------------------------------------------------------------
   logic [ChanW-1:0] x_val;
   logic [ChanW:0]   m2;
   logic [ChanW+1:0] cm_sum, xm_sum, mm_sum;
   logic [ChanW-1:0] cm, xm, mm;

   always_comb begin
      x_val  = s5_q_ff[RECIP_SHIFT +: ChanW];
      m2     = s5_twol_ff - {1'b0, s5_c_ff};
      cm_sum = {1'b0, s5_twol_ff} + {2'b0, s5_c_ff} + 18'd1;
      xm_sum = {1'b0, m2} + {1'b0, x_val, 1'b0} + 18'd1;
      mm_sum = {1'b0, m2} + 18'd1;
      cm     = sat16(cm_sum[ChanW+1:1]);
      xm     = sat16(xm_sum[ChanW+1:1]);
      mm     = sat16(mm_sum[ChanW+1:1]);

      case (s5_sec_ff)
         SEC_RED_YEL: begin s6_r_in = cm; s6_g_in = xm; s6_b_in = mm; end
         SEC_YEL_GRN: begin s6_r_in = xm; s6_g_in = cm; s6_b_in = mm; end
         SEC_GRN_CYN: begin s6_r_in = mm; s6_g_in = cm; s6_b_in = xm; end
         SEC_CYN_BLU: begin s6_r_in = mm; s6_g_in = xm; s6_b_in = cm; end
         SEC_BLU_MAG: begin s6_r_in = xm; s6_g_in = mm; s6_b_in = cm; end
         default: begin s6_r_in = cm; s6_g_in = mm; s6_b_in = xm; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_r_ff <= s6_r_in;
         s6_g_ff <= s6_g_in;
         s6_b_ff <= s6_b_in;
         s6_a_ff <= s5_a_ff;
      end
   end

   assign rsp_valid     = vld_ff[NumStages-1];
   assign rsp_red       = s6_r_ff;
   assign rsp_green     = s6_g_ff;
   assign rsp_blue      = s6_b_ff;
   assign rsp_alpha_out = s6_a_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // the pipeline only pushes back when the output beat is held
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req stalled while rsp side can drain");

   // reciprocal divide never yields X above chroma
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (x_val <= s5_c_ff))
      else $error("hue-scaled chroma exceeds chroma");

   // chroma never exceeds 2L, so m stays non-negative
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (s5_twol_ff >= {1'b0, s5_c_ff}))
      else $error("chroma larger than twice lightness");

   // a beat accepted into stage 1 shows up there in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted beat lost at stage one");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hsl to rgb pixel converter
// ----------------------------------------------------------------------------
// Drives hsl pixels with alpha into the req channel and collects rgb pixels
// from the rsp channel. Both sides idle at random, with some bursts of no
// idling. A small scoreboard predicts each rgb pixel from the accepted hsl
// beat and compares the results in order. A directed set covers sector
// edges, field extremes and hue clamping. A longer random run follows, with
// one pause in which the bench waits for every pending pixel to drain.
// ----------------------------------------------------------------------------
module tb
   import hsl_pkg::*;
();

   localparam int unsigned RANDOM_PIXELS  = 1750;
   localparam int unsigned MAX_WAIT       = 8;
   localparam int unsigned DRAIN_CYCLES   = 24;    // pipeline is six deep, with margin
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic [HueW-1:0]  hue;
      logic [ChanW-1:0] sat;
      logic [ChanW-1:0] light;
      logic [ChanW-1:0] alpha;
   } hsl_pixel_type;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] alpha;
   } rgba_type;

   // keeps the rgb pixels still owed by the block, oldest first
   class rgb_scoreboard;
      rgba_type    expected_rgb_q[$];
      int unsigned mismatches;
      int unsigned pixels_in;
      int unsigned pixels_out;

      function new();
         mismatches = 0;
         pixels_in  = 0;
         pixels_out = 0;
      endfunction

      function logic [ChanW-1:0] clip_full(input logic [33:0] v);
         return (v > FULL) ? FULL : v[ChanW-1:0];
      endfunction

      // hsl to rgb in integer units of 1/65535, hue in 1/64 degree
      function rgba_type rgb_from_hsl(input hsl_pixel_type px);
         logic [33:0] h, s, l, two_l, d, c, sidx, r, f, x, m2;
         logic [ChanW-1:0] cm, xm, mm;
         sector_type sec;
         rgba_type res;
         h = 34'((px.hue > HUE_MAX) ? HUE_MAX : px.hue);
         s = 34'(px.sat);
         l = 34'(px.light);
         two_l = l << 1;
         // distance of 2l from full scale, then chroma rounded half down
         d = (two_l >= FULL) ? two_l - FULL : FULL - two_l;
         c = ((FULL - d) * s + ROUND_C) / FULL;
         sidx = h / SECTOR_UNITS;
         sec  = sector_type'(sidx[2:0]);
         r = h % SECTOR_UNITS;
         // odd sectors run the hue offset backwards
         f = sidx[0] ? SECTOR_UNITS - r : r;
         x = (c * f + ROUND_X) / SECTOR_UNITS;
         // sums in half units so m = l - c/2 stays exact
         m2 = two_l - c;
         cm = clip_full((two_l + c + 1) >> 1);
         xm = clip_full((m2 + (x << 1) + 1) >> 1);
         mm = clip_full((m2 + 1) >> 1);
         case (sec)
            SEC_RED_YEL: begin res.red = cm; res.green = xm; res.blue = mm; end
            SEC_YEL_GRN: begin res.red = xm; res.green = cm; res.blue = mm; end
            SEC_GRN_CYN: begin res.red = mm; res.green = cm; res.blue = xm; end
            SEC_CYN_BLU: begin res.red = mm; res.green = xm; res.blue = cm; end
            SEC_BLU_MAG: begin res.red = xm; res.green = mm; res.blue = cm; end
            default:     begin res.red = cm; res.green = mm; res.blue = xm; end
         endcase
         res.alpha = px.alpha;
         return res;
      endfunction

      function void note_pixel(input hsl_pixel_type px);
         expected_rgb_q.push_back(rgb_from_hsl(px));
         pixels_in++;
      endfunction

      function void check_pixel(input rgba_type got);
         rgba_type want;
         if (expected_rgb_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp beat with no pixel outstanding: r %h g %h b %h a %h",
                        got.red, got.green, got.blue, got.alpha);
            return;
         end
         want = expected_rgb_q.pop_front();
         pixels_out++;
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel %0d: expected r %h g %h b %h a %h, got r %h g %h b %h a %h",
                        pixels_out, want.red, want.green, want.blue, want.alpha,
                        got.red, got.green, got.blue, got.alpha);
         end
      endfunction

      function int unsigned pending();
         return expected_rgb_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [HueW-1:0]  req_hue;
   logic [ChanW-1:0] req_saturation;
   logic [ChanW-1:0] req_lightness;
   logic [ChanW-1:0] req_alpha_in;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [ChanW-1:0] rsp_red;
   logic [ChanW-1:0] rsp_green;
   logic [ChanW-1:0] rsp_blue;
   logic [ChanW-1:0] rsp_alpha_out;

   rgb_scoreboard pixel_board;
   bit            burst;          // when set neither side idles
   int unsigned   clamped_pixels;
   int unsigned   directed_pixels;
   int unsigned   idle_cycles;

   hsl_to_rgb_convert i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .req_alpha_in   (req_alpha_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha_out  (rsp_alpha_out)
   );

   // 12 unit period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ends the run when neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d pixels pending",
                     WATCHDOG_LIMIT, pixel_board.pending());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic int unsigned draw_wait();
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic hsl_pixel_type make_pixel(input int unsigned h, input int unsigned s,
                                               input int unsigned l, input int unsigned a);
      hsl_pixel_type px;
      px.hue   = h[HueW-1:0];
      px.sat   = s[ChanW-1:0];
      px.light = l[ChanW-1:0];
      px.alpha = a[ChanW-1:0];
      return px;
   endfunction

   // values around zero, half scale and full scale
   function automatic int unsigned edge_value();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return 32767;
         3:       return 32768;
         4:       return 65534;
         default: return 65535;
      endcase
   endfunction

   function automatic hsl_pixel_type random_pixel();
      hsl_pixel_type px;
      int unsigned kind;
      int unsigned offs;
      kind = $urandom_range(0, 9);
      px = make_pixel($urandom_range(0, HUE_MAX), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
      case (kind)
         0: px.hue = HueW'($urandom_range(int'(HUE_MAX) + 1, 32767));   // clamped hue
         1: begin
            // hue at or beside a sector edge, or at the middle of a sector
            case ($urandom_range(0, 4))
               0:       offs = 0;
               1:       offs = 1;
               2:       offs = 1919;
               3:       offs = 1920;
               default: offs = 3839;
            endcase
            px.hue = HueW'($urandom_range(0, 5) * int'(SECTOR_UNITS) + offs);
         end
         2: px.sat   = ChanW'(edge_value());
         3: px.light = ChanW'(edge_value());
         4: begin
            px.sat   = ChanW'(edge_value());
            px.light = ChanW'(edge_value());
         end
         default: ;
      endcase
      return px;
   endfunction

   // one req beat, after an optional idle gap with valid low
   task automatic send_pixel(input hsl_pixel_type px, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= px.hue;
      req_saturation <= px.sat;
      req_lightness  <= px.light;
      req_alpha_in   <= px.alpha;
      do @(posedge clock); while (!req_ready);
      pixel_board.note_pixel(px);
      if (px.hue > HUE_MAX)
         clamped_pixels++;
   endtask

   // sender holds off until the block has delivered everything
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pixel_board.pending() != 0) @(posedge clock);
   endtask

   task automatic collect_results();
      int unsigned stall;
      rgba_type got;
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.red   = rsp_red;
         got.green = rsp_green;
         got.blue  = rsp_blue;
         got.alpha = rsp_alpha_out;
         pixel_board.check_pixel(got);
      end
   endtask

   task automatic run_directed();
      int unsigned pts[3];
      int unsigned k;
      int unsigned p;
      pts = '{0, 1920, 3839};
      // black and white, transparent and opaque
      send_pixel(make_pixel(0, 0, 0, 0), draw_wait());
      send_pixel(make_pixel(0, 65535, 65535, 65535), draw_wait());
      // hue past the top, at the top and at the largest code
      send_pixel(make_pixel(32767, 65535, 32768, 16'h1234), draw_wait());
      send_pixel(make_pixel(int'(HUE_MAX) + 1, 65535, 32767, 16'h8001), draw_wait());
      send_pixel(make_pixel(int'(HUE_MAX), 65535, 32768, 16'h7ffe), draw_wait());
      // full saturation near full lightness, where the channel sum reaches the top
      send_pixel(make_pixel(1920, 65535, 65534, 16'hffff), draw_wait());
      // start, middle and end of every sector
      for (k = 0; k < 6; k++) begin
         for (p = 0; p < 3; p++) begin
            send_pixel(make_pixel(k * int'(SECTOR_UNITS) + pts[p],
                                  (p == 0) ? 65535 : $urandom_range(0, 65535),
                                  (p == 1) ? 32768 : $urandom_range(0, 65535),
                                  $urandom_range(0, 65535)), draw_wait());
         end
      end
      directed_pixels = pixel_board.pixels_in;
   endtask

   initial begin
      int unsigned n;
      hsl_pixel_type px;
      pixel_board     = new();
      burst           = 1'b0;
      clamped_pixels  = 0;
      directed_pixels = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_hue         = '0;
      req_saturation  = '0;
      req_lightness   = '0;
      req_alpha_in    = '0;
      rsp_ready       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fork
         collect_results();
      join_none

      run_directed();
      hold_until_drained();

      for (n = 0; n < RANDOM_PIXELS; n++) begin
         // switch between idling and back-to-back stretches
         if (n % 64 == 0)
            burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_PIXELS / 2)
            hold_until_drained();
         px = random_pixel();
         send_pixel(px, draw_wait());
      end
      req_valid <= 1'b0;

      while (pixel_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d of %0d hsl pixels: %0d directed, %0d with hue clamped",
               pixel_board.pixels_out, pixel_board.pixels_in, directed_pixels,
               clamped_pixels);
      $display("all six sectors, sector edges and field extremes under random stalls");
      if (pixel_board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", pixel_board.mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/hsl_pkg.sv
rtl/hsl_to_rgb_convert.sv
verif/tb.sv
